// File: rtl/integer_to_ascii_formatter_defines.svh
// assertion macros used by the checker file
`ifndef INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_DEFINES_SVH

// same-cycle implication, off while reset is asserted
`define ITAF_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ITAF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/itaf_pkg.sv
package itaf_pkg;

    // widths and sizes
    localparam int VALUE_WIDTH  = 64;
    localparam int MAX_CHARS    = 20;
    localparam int INPUT_W      = 64;
    localparam int NUM_DIGITS   = 20;
    localparam int HEX_W        = NUM_DIGITS * 4;
    localparam int CHAR_COUNT_W = 5;
    localparam int REMAIN_W     = $clog2(NUM_DIGITS + 1);
    localparam int BIT_CNT_W    = $clog2(VALUE_WIDTH + 1);
    localparam int PFX_IDX_W    = 3;

    // ascii codes
    localparam logic [7:0] CHAR_ZERO   = 8'h30;
    localparam logic [7:0] CHAR_A_BASE = 8'h57;
    localparam logic [7:0] CHAR_MINUS  = 8'h2d;
    localparam logic [7:0] CHAR_X      = 8'h78;
    localparam logic [7:0] CHAR_LPAREN = 8'h28;
    localparam logic [7:0] CHAR_N      = 8'h6e;
    localparam logic [7:0] CHAR_I      = 8'h69;
    localparam logic [7:0] CHAR_L      = 8'h6c;
    localparam logic [7:0] CHAR_RPAREN = 8'h29;

    typedef enum logic [1:0] {
        CMD_SIGNED   = 2'd0,
        CMD_UNSIGNED = 2'd1,
        CMD_HEX      = 2'd2,
        CMD_POINTER  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        PFX_NONE  = 2'd0,
        PFX_MINUS = 2'd1,
        PFX_HEX   = 2'd2,
        PFX_NIL   = 2'd3
    } prefix_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_LOAD   = 2'd1,
        CELL_DABBLE = 2'd2,
        CELL_MOVE   = 2'd3
    } cell_op_t;

    // control from the sequencer to the digit chain
    typedef struct packed {
        cell_op_t op;
        logic     bit_in;
    } chain_ctrl_t;

    // digit 0..15 to its lowercase ascii character
    function automatic logic [7:0] ascii_of(input logic [3:0] d);
        logic [7:0] base;
        base = (d < 4'd10) ? CHAR_ZERO : CHAR_A_BASE;
        return base + {4'b0000, d};
    endfunction

    // number of characters in front of the digits
    function automatic logic [PFX_IDX_W-1:0] prefix_len(input prefix_t p);
        logic [PFX_IDX_W-1:0] n;
        case (p)
            PFX_MINUS: n = PFX_IDX_W'(1);
            PFX_HEX:   n = PFX_IDX_W'(2);
            PFX_NIL:   n = PFX_IDX_W'(5);
            default:   n = PFX_IDX_W'(0);
        endcase
        return n;
    endfunction

    // prefix character at a given position
    function automatic logic [7:0] prefix_char(input prefix_t p,
                                               input logic [PFX_IDX_W-1:0] idx);
        logic [7:0] c;
        c = CHAR_ZERO;
        case (p)
            PFX_MINUS: c = CHAR_MINUS;
            PFX_HEX:   c = (idx == PFX_IDX_W'(0)) ? CHAR_ZERO : CHAR_X;
            PFX_NIL:
            begin
                case (idx)
                    3'd0:    c = CHAR_LPAREN;
                    3'd1:    c = CHAR_N;
                    3'd2:    c = CHAR_I;
                    3'd3:    c = CHAR_L;
                    default: c = CHAR_RPAREN;
                endcase
            end
            default:   c = CHAR_ZERO;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/integer_to_ascii_formatter.sv
// channel   signals                            handshake
// input     command, value                     accepted when start && !busy
// result    character, last, char_count        one cycle each, marked by strobe
//
// decimal items: accept, a double-dabble step per value bit (VALUE_WIDTH, 64) in the
// digit chain, the prefix if any, then a walk of the chain top first
// (leading zeros are dropped silently, at most one character per cycle).
// hex and pointer items skip the dabble phase; "(nil)" is five prefix characters.
// rst_n clears the sequencer and the result strobe at once; the digit cells
// carry no reset. results cannot be stalled; busy falls with the last one.
module integer_to_ascii_formatter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          command,
    input  logic [itaf_pkg::INPUT_W-1:0]        value,
    output logic                                strobe,
    output logic [7:0]                          character,
    output logic                                last,
    output logic [itaf_pkg::CHAR_COUNT_W-1:0]   char_count
);
    import itaf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_CONVERT = 4'b0010,
        S_PREFIX  = 4'b0100,
        S_DIGITS  = 4'b1000
    } state_t;

    state_t                  state_reg, state_next;
    prefix_t                 prefix_reg, prefix_next;
    logic [PFX_IDX_W-1:0]    pfx_idx_reg, pfx_idx_next;
    logic [CHAR_COUNT_W-1:0] emitted_reg, emitted_next;
    logic [REMAIN_W-1:0]     remain_reg, remain_next;
    logic [BIT_CNT_W-1:0]    bit_cnt_reg, bit_cnt_next;
    logic [VALUE_WIDTH-1:0]  shift_reg, shift_next;
    logic                    strobe_reg, strobe_next;
    logic                    last_reg, last_next;
    logic [CHAR_COUNT_W-1:0] count_reg, count_next;
    logic [7:0]              char_reg, char_next;

    chain_ctrl_t                chain_ctrl;
    logic [NUM_DIGITS-1:0][3:0] load_digits;
    logic [3:0]                 top_digit;

    cmd_t                    cmd;
    logic [VALUE_WIDTH-1:0]  masked;
    logic [31:0]             low_word;
    logic [31:0]             mag32;
    logic [HEX_W-1:0]        hex_ext;
    logic [CHAR_COUNT_W-1:0] emitted_inc;
    logic                    digit_fin;

    // input decode
    assign cmd      = cmd_t'(command);
    assign masked   = value[VALUE_WIDTH-1:0];
    assign low_word = value[31:0];
    assign mag32    = low_word[31] ? (~low_word + 32'd1) : low_word;
    assign hex_ext  = HEX_W'(masked);

    assign emitted_inc = emitted_reg + CHAR_COUNT_W'(1);
    assign digit_fin   = (remain_reg == REMAIN_W'(1)) ||
                         (emitted_inc == CHAR_COUNT_W'(MAX_CHARS));

    // hex and pointer digits load straight into the cells, decimal starts from zero
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            load_digits[i] = ((cmd == CMD_HEX) || (cmd == CMD_POINTER)) ?
                             hex_ext[4*i +: 4] : 4'd0;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        prefix_next     = prefix_reg;
        pfx_idx_next    = pfx_idx_reg;
        emitted_next    = emitted_reg;
        remain_next     = remain_reg;
        bit_cnt_next    = bit_cnt_reg;
        shift_next      = shift_reg;
        strobe_next     = 1'b0;
        last_next       = 1'b0;
        count_next      = '0;
        char_next       = char_reg;
        chain_ctrl.op   = CELL_HOLD;
        chain_ctrl.bit_in = shift_reg[VALUE_WIDTH-1];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    chain_ctrl.op = CELL_LOAD;
                    pfx_idx_next  = '0;
                    emitted_next  = '0;
                    remain_next   = REMAIN_W'(NUM_DIGITS);
                    bit_cnt_next  = BIT_CNT_W'(VALUE_WIDTH);
                    shift_next    = (cmd == CMD_SIGNED) ? VALUE_WIDTH'(mag32) : masked;
                    case (cmd)
                        CMD_SIGNED:  prefix_next = low_word[31] ? PFX_MINUS : PFX_NONE;
                        CMD_POINTER: prefix_next = (masked == '0) ? PFX_NIL : PFX_HEX;
                        default:     prefix_next = PFX_NONE;
                    endcase
                    if ((cmd == CMD_SIGNED) || (cmd == CMD_UNSIGNED))
                    begin
                        state_next = S_CONVERT;
                    end
                    else if (cmd == CMD_POINTER)
                    begin
                        state_next = S_PREFIX;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end

            S_CONVERT:
            begin
                chain_ctrl.op = CELL_DABBLE;
                shift_next    = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
                bit_cnt_next  = bit_cnt_reg - BIT_CNT_W'(1);
                if (bit_cnt_reg == BIT_CNT_W'(1))
                begin
                    state_next = (prefix_reg == PFX_NONE) ? S_DIGITS : S_PREFIX;
                end
            end

            S_PREFIX:
            begin
                strobe_next  = 1'b1;
                char_next    = prefix_char(prefix_reg, pfx_idx_reg);
                emitted_next = emitted_inc;
                pfx_idx_next = pfx_idx_reg + PFX_IDX_W'(1);
                if (pfx_idx_reg == prefix_len(prefix_reg) - PFX_IDX_W'(1))
                begin
                    if (prefix_reg == PFX_NIL)
                    begin
                        last_next  = 1'b1;
                        count_next = emitted_inc;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_DIGITS;
                    end
                end
            end

            S_DIGITS:
            begin
                chain_ctrl.op = CELL_MOVE;
                remain_next   = remain_reg - REMAIN_W'(1);
                // drop leading zeros, but always keep the final digit
                if (!((top_digit == 4'd0) && (remain_reg > REMAIN_W'(1))) ||
                    (emitted_reg != '0 && prefix_reg == PFX_NONE))
                begin
                    strobe_next  = 1'b1;
                    char_next    = ascii_of(top_digit);
                    emitted_next = emitted_inc;
                    if (digit_fin)
                    begin
                        last_next  = 1'b1;
                        count_next = emitted_inc;
                        state_next = S_IDLE;
                    end
                end
                else if ((top_digit != 4'd0) || (remain_reg == REMAIN_W'(1)))
                begin
                    strobe_next = 1'b0;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // once a digit went out every following one is printed, zero or not
        if ((state_reg == S_DIGITS) && (emitted_reg > CHAR_COUNT_W'(0)) &&
            (emitted_reg != CHAR_COUNT_W'(prefix_len(prefix_reg))))
        begin
            strobe_next  = 1'b1;
            char_next    = ascii_of(top_digit);
            emitted_next = emitted_inc;
            last_next    = digit_fin;
            count_next   = digit_fin ? emitted_inc : '0;
            state_next   = digit_fin ? S_IDLE : S_DIGITS;
        end
    end

    itaf_digit_chain u_chain (
        .clk         (clk),
        .ctrl        (chain_ctrl),
        .load_digits (load_digits),
        .top_digit   (top_digit)
    );

    // control and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            strobe_reg <= 1'b0;
            last_reg   <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
            last_reg   <= last_next;
            count_reg  <= count_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prefix_reg  <= prefix_next;
        pfx_idx_reg <= pfx_idx_next;
        emitted_reg <= emitted_next;
        remain_reg  <= remain_next;
        bit_cnt_reg <= bit_cnt_next;
        shift_reg   <= shift_next;
        char_reg    <= char_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign character  = char_reg;
    assign last       = last_reg;
    assign char_count = count_reg;

endmodule

// File: rtl/itaf_digit_cell.sv
module itaf_digit_cell (
    input  logic             clk,
    input  itaf_pkg::cell_op_t op,
    input  logic [3:0]       load_digit,
    input  logic [3:0]       move_in,
    input  logic             carry_in,
    output logic [3:0]       digit,
    output logic             carry_out
);
    import itaf_pkg::*;

    logic [3:0] digit_reg;
    logic [3:0] digit_next;
    logic [3:0] adjusted;

    // add three before the shift when the digit would pass nine
    assign adjusted  = (digit_reg >= 4'd5) ? (digit_reg + 4'd3) : digit_reg;
    assign carry_out = adjusted[3];
    assign digit     = digit_reg;

    // digit update
    always_comb
    begin
        case (op)
            CELL_LOAD:   digit_next = load_digit;
            CELL_DABBLE: digit_next = {adjusted[2:0], carry_in};
            CELL_MOVE:   digit_next = move_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// File: rtl/itaf_digit_chain.sv
module itaf_digit_chain (
    input  logic                                   clk,
    input  itaf_pkg::chain_ctrl_t                  ctrl,
    input  logic [itaf_pkg::NUM_DIGITS-1:0][3:0]   load_digits,
    output logic [3:0]                             top_digit
);
    import itaf_pkg::*;

    logic [NUM_DIGITS-1:0][3:0] digits;
    logic [NUM_DIGITS-1:0][3:0] move_in;
    logic [NUM_DIGITS-1:0]      carry_in;
    logic [NUM_DIGITS-1:0]      carry_out;

    // cell 0 is the least significant digit, digits move toward the top cell
    assign move_in[0]  = 4'd0;
    assign carry_in[0] = ctrl.bit_in;

    genvar gi;
    generate
        for (gi = 1; gi < NUM_DIGITS; gi++)
        begin : g_link
            assign move_in[gi]  = digits[gi-1];
            assign carry_in[gi] = carry_out[gi-1];
        end

        for (gi = 0; gi < NUM_DIGITS; gi++)
        begin : g_cell
            itaf_digit_cell u_cell (
                .clk        (clk),
                .op         (ctrl.op),
                .load_digit (load_digits[gi]),
                .move_in    (move_in[gi]),
                .carry_in   (carry_in[gi]),
                .digit      (digits[gi]),
                .carry_out  (carry_out[gi])
            );
        end
    endgenerate

    assign top_digit = digits[NUM_DIGITS-1];

endmodule

// File: rtl/itaf_checker.sv
`include "integer_to_ascii_formatter_defines.svh"

module itaf_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic                                busy,
    input  logic                                strobe,
    input  logic                                last,
    input  logic [itaf_pkg::CHAR_COUNT_W-1:0]   char_count
);
    import itaf_pkg::*;

    // count only on the closing character of an item
    `ITAF_ASSERT_IMPLIES(a_count_zero, clk, rst_n, strobe && !last, char_count == '0, "count on a non-final character")
    `ITAF_ASSERT_IMPLIES(a_count_set, clk, rst_n, strobe && last, (char_count != '0) && (char_count <= CHAR_COUNT_W'(MAX_CHARS)), "bad count on the final character")

    // an accepted item keeps the block busy in the next cycle
    `ITAF_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy, "busy did not rise after an accepted item")

    // the next item cannot produce a character right after the final one
    `ITAF_ASSERT_NEXT(a_gap_after_last, clk, rst_n, strobe && last, !strobe, "character right after the final one")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);
